FILE: hdl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg: shared types and codes for the counting semaphore bank
// Opcodes, status codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned PID_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_OPEN    = 3'd0,
    OP_CLOSE   = 3'd1,
    OP_POST    = 3'd2,
    OP_WAIT    = 3'd3,
    OP_VALUE   = 3'd4,
    OP_USERS   = 3'd5,
    OP_WAITERS = 3'd6,
    OP_REMOVE  = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADH     = 3'd1,
    ST_NOSLOT   = 3'd2,
    ST_QFULL    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_OVF      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RM_RD,
    S_RM_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic scan_clr;  // reset scan index
    logic scan_step; // examine one slot, advance
    logic exec;      // perform the simple ops
    logic rm_clr;    // start a queue walk
    logic rm_rd;     // issue read of queue entry at walk index
    logic rm_chk;    // compare read entry
    logic sh_rd;     // read the entry after the walk index
    logic sh_wr;     // write it down one place, advance
    logic finish;    // finalise result
  } csb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_open;
    logic is_remove;
    logic scan_last;
    logic scan_hit;
    logic rm_empty;  // walk over the whole fill finished
    logic rm_match;
    logic sh_last;
  } csb_sts_t;

endpackage

FILE: hdl/counting_semaphore_bank_top.sv
// ----------------------------------------------------------------------------
// counting_semaphore_bank_top: bank of named counting semaphores
// Stream in one request transaction, stream out one result transaction.
// ----------------------------------------------------------------------------
// Sequence: open scans the slot table, one slot compared per cycle;
//   remove walks the waiter RAM for the caller's pid, then shifts the
//   later entries down one place; other ops execute directly.
// Throughput: one transaction at a time; the next is taken once the
//   result is registered, while that result may still wait downstream.
// Reset: rst synchronous, active high; clears slot flags and queue pointers.
module counting_semaphore_bank_top #(
  parameter int unsigned NUM_SEMS   = 16,
  parameter int unsigned WAIT_DEPTH = 16,
  parameter int unsigned NAME_BITS  = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[2:0], handle[6:3], name_key[70:7], initial_count[86:71],
  // pid[94:87], zero pad
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], handle_out[6:3], read_value[22:7], block_caller[23],
  // wake_valid[24], wake_pid[32:25], zero pad
  output logic [39:0]  m_tdata
);
  import csb_pkg::*;

  csb_cmd_t cmd;
  csb_sts_t sts;
  logic in_fire, out_fire;
  logic [2:0]  status;
  logic [3:0]  handle_out;
  logic [15:0] read_value;
  logic block_caller, wake_valid;
  logic [7:0] wake_pid;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  csb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_tvalid),
    .out_fire(out_fire), .sts(sts), .in_ready(s_tready), .cmd(cmd)
  );

  csb_dp #(.NUM_SEMS(NUM_SEMS), .WAIT_DEPTH(WAIT_DEPTH), .NAME_BITS(NAME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .opcode(s_tdata[2:0]), .handle(s_tdata[6:3]), .name_key(s_tdata[70:7]),
    .initial_count(s_tdata[86:71]), .caller_pid(s_tdata[94:87]),
    .sts(sts), .status(status), .handle_out(handle_out), .read_value(read_value),
    .block_caller(block_caller), .wake_valid(wake_valid), .wake_pid(wake_pid)
  );

  // result valid: set on finish, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, wake_pid, wake_valid, block_caller, read_value,
                    handle_out, status};
endmodule

FILE: hdl/csb_ram.sv
// ----------------------------------------------------------------------------
// csb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module csb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl: sequencer for the semaphore bank
// Steps the datapath through slot scan, execute, queue walk and shift phases.
// ----------------------------------------------------------------------------
module csb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_busy,
  input  logic              out_fire,
  input  csb_pkg::csb_sts_t sts,
  output logic              in_ready,
  output csb_pkg::csb_cmd_t cmd
);
  import csb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.is_open) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last || sts.scan_hit) state_next = S_EXEC;
        end else if (sts.is_remove) begin
          cmd.rm_clr = 1'b1;
          state_next = S_RM_RD;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_DONE;
      end
      S_RM_RD: begin
        if (sts.rm_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.rm_rd = 1'b1;
          state_next = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        cmd.rm_chk = 1'b1;
        if (sts.rm_match) state_next = S_SH_RD;
        else state_next = S_RM_RD;
      end
      S_SH_RD: begin
        if (sts.sh_last) begin
          state_next = S_DONE;
        end else begin
          cmd.sh_rd = 1'b1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_next = S_SH_RD;
      end
      S_DONE: begin
        if (!out_busy || out_fire) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/csb_dp.sv
// ----------------------------------------------------------------------------
// csb_dp: semaphore bank datapath
// Slot tables, per-slot queue pointers, waiter RAM and result register.
// ----------------------------------------------------------------------------
module csb_dp #(
  parameter int unsigned NUM_SEMS   = 16,
  parameter int unsigned WAIT_DEPTH = 16,
  parameter int unsigned NAME_BITS  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  csb_pkg::csb_cmd_t      cmd,
  input  logic [2:0]             opcode,
  input  logic [3:0]             handle,
  input  logic [63:0]            name_key,
  input  logic [15:0]            initial_count,
  input  logic [7:0]             caller_pid,
  output csb_pkg::csb_sts_t      sts,
  output logic [2:0]             status,
  output logic [3:0]             handle_out,
  output logic [15:0]            read_value,
  output logic                   block_caller,
  output logic                   wake_valid,
  output logic [7:0]             wake_pid
);
  import csb_pkg::*;

  localparam int unsigned SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned QW = $clog2(WAIT_DEPTH);
  localparam int unsigned FW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned SCW = $clog2(NUM_SEMS + 1);

  // slot state
  logic [NUM_SEMS-1:0] in_use;
  logic [NAME_BITS-1:0] slot_name [NUM_SEMS];
  logic [CNT_W-1:0]     sem_count [NUM_SEMS];
  logic [CNT_W-1:0]     slot_users [NUM_SEMS];
  logic [QW-1:0]        qhead [NUM_SEMS];
  logic [FW-1:0]        qfill [NUM_SEMS];

  // captured item
  opcode_t              op;
  logic [3:0]           h;
  logic [NAME_BITS-1:0] key;
  logic [CNT_W-1:0]     init;
  logic [PID_W-1:0]     pid;

  // scan
  logic [SW-1:0] idx;
  logic          found, free_ok;
  logic [SW-1:0] found_idx, free_idx;

  // queue walk
  logic [FW-1:0] walk;
  logic          rm_found;

  // result
  status_t        res_st;
  logic [SW-1:0]  res_h;
  logic [CNT_W-1:0] res_rv;
  logic           res_blk, res_wv;
  logic [PID_W-1:0] res_wpid;
  logic           pop_rd;

  // addressed slot, valid when handle in range and slot in use
  logic          h_ok;
  logic [SW-1:0] hs;
  assign h_ok = ({28'd0, h} < 32'(NUM_SEMS)) && in_use[SW'(h)];
  assign hs = SW'(h);

  // waiter RAM
  logic                  we;
  logic [SW+QW-1:0]      waddr, raddr;
  logic [PID_W-1:0]      wdata, rdata;

  csb_ram #(.WIDTH(PID_W), .DEPTH(NUM_SEMS * WAIT_DEPTH)) u_wait_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [QW-1:0] qpos(logic [QW-1:0] hd, logic [FW-1:0] k);
    logic [FW:0] s;
    s = {1'b0, (FW)'(hd)} + {1'b0, k};
    if (s >= (FW+1)'(WAIT_DEPTH)) s = s - (FW+1)'(WAIT_DEPTH);
    return s[QW-1:0];
  endfunction

  // RAM port selection
  always_comb begin
    we = 1'b0;
    waddr = {hs, qpos(qhead[hs], qfill[hs])};
    wdata = pid;
    raddr = {hs, qpos(qhead[hs], walk)};
    if (cmd.exec && op == OP_POST) raddr = {hs, qhead[hs]};
    if (cmd.exec && op == OP_WAIT && h_ok && sem_count[hs] == '0
        && qfill[hs] < FW'(WAIT_DEPTH)) we = 1'b1;
    if (cmd.sh_rd) raddr = {hs, qpos(qhead[hs], walk + FW'(1))};
    if (cmd.sh_wr) begin
      we = 1'b1;
      waddr = {hs, qpos(qhead[hs], walk)};
      wdata = rdata;
    end
  end

  assign sts.is_open   = (op == OP_OPEN);
  assign sts.is_remove = (op == OP_REMOVE) && h_ok;
  assign sts.scan_last = (SCW'(idx) == SCW'(NUM_SEMS - 1));
  assign sts.scan_hit  = in_use[idx] && slot_name[idx] == key;
  assign sts.rm_empty  = (walk >= qfill[hs]);
  assign sts.rm_match  = (rdata == pid);
  assign sts.sh_last   = (walk + FW'(1) >= qfill[hs]);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        qhead[i] <= '0;
        qfill[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        op <= opcode_t'(opcode);
        h <= handle;
        key <= name_key[NAME_BITS-1:0];
        init <= initial_count;
        pid <= caller_pid;
        res_st <= ST_OK; res_h <= '0; res_rv <= '0;
        res_blk <= 1'b0; res_wv <= 1'b0; res_wpid <= '0;
        pop_rd <= 1'b0;
      end
      if (cmd.scan_clr) begin
        idx <= '0; found <= 1'b0; free_ok <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (sts.scan_hit) begin
          found <= 1'b1; found_idx <= idx;
        end
        if (!in_use[idx] && !free_ok) begin
          free_ok <= 1'b1; free_idx <= idx;
        end
        if (!sts.scan_last) idx <= idx + SW'(1);
      end
      if (cmd.exec) begin
        if (op == OP_OPEN) begin
          if (found) begin
            if (slot_users[found_idx] == CNT_MAX) res_st <= ST_OVF;
            else begin
              slot_users[found_idx] <= slot_users[found_idx] + 1'b1;
              res_h <= found_idx;
            end
          end else if (free_ok) begin
            in_use[free_idx] <= 1'b1;
            slot_name[free_idx] <= key;
            sem_count[free_idx] <= init;
            slot_users[free_idx] <= 16'd1;
            qhead[free_idx] <= '0;
            qfill[free_idx] <= '0;
            res_h <= free_idx;
          end else res_st <= ST_NOSLOT;
        end else if (!h_ok) begin
          res_st <= ST_BADH;
        end else begin
          unique case (op)
            OP_CLOSE: begin
              if (slot_users[hs] <= 16'd1) begin
                slot_users[hs] <= '0;
                in_use[hs] <= 1'b0;
                qhead[hs] <= '0;
                qfill[hs] <= '0;
              end else slot_users[hs] <= slot_users[hs] - 1'b1;
            end
            OP_POST: begin
              if (qfill[hs] != '0) begin
                res_wv <= 1'b1;
                pop_rd <= 1'b1;
                qhead[hs] <= qpos(qhead[hs], FW'(1));
                qfill[hs] <= qfill[hs] - FW'(1);
              end else if (sem_count[hs] == CNT_MAX) res_st <= ST_OVF;
              else sem_count[hs] <= sem_count[hs] + 1'b1;
            end
            OP_WAIT: begin
              if (sem_count[hs] != '0) sem_count[hs] <= sem_count[hs] - 1'b1;
              else if (qfill[hs] >= FW'(WAIT_DEPTH)) res_st <= ST_QFULL;
              else begin
                qfill[hs] <= qfill[hs] + FW'(1);
                res_blk <= 1'b1;
              end
            end
            OP_VALUE:   res_rv <= sem_count[hs];
            OP_USERS:   res_rv <= slot_users[hs];
            OP_WAITERS: res_rv <= CNT_W'(qfill[hs]);
            default: ;
          endcase
        end
      end
      // popped waiter arrives in the cycle after the read; hold it while the
      // result waits for the output register
      if (pop_rd) begin
        res_wpid <= rdata;
        pop_rd <= 1'b0;
      end
      if (cmd.rm_clr) begin
        walk <= '0; rm_found <= 1'b0;
      end
      if (cmd.rm_chk && !sts.rm_match) walk <= walk + FW'(1);
      if (cmd.rm_chk && sts.rm_match) rm_found <= 1'b1;
      if (cmd.sh_wr) walk <= walk + FW'(1);
      if (cmd.finish && op == OP_REMOVE && h_ok) begin
        if (rm_found) qfill[hs] <= qfill[hs] - FW'(1);
      end
      if (cmd.finish) begin
        status <= (op == OP_REMOVE && h_ok && !rm_found) ? ST_NOTFOUND : res_st;
        handle_out <= 4'(res_h);
        read_value <= res_rv;
        block_caller <= res_blk;
        wake_valid <= res_wv;
        wake_pid <= pop_rd ? rdata : res_wpid;
      end
    end
  end
endmodule

FILE: hdl/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker: port-level checks for the semaphore bank
// Watches handshake and result fields on the top level.
// ----------------------------------------------------------------------------
module csb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed under stall");

  a_one_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid || $past(m_tvalid))
    else $error("result appeared one cycle after acceptance");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[23] && m_tdata[24]))
    else $error("block and wake in one result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
    else $error("undefined status code");
endmodule

bind counting_semaphore_bank_top csb_checker u_csb_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
